@@ rtl/mnc_pkg.sv @@
package mnc_pkg;

	// default sizes
	localparam int STACK_DEPTH_DEF = 16;
	localparam int TABLE_LEN_DEF   = 24;

	// byte classes
	localparam logic [7:0] REALTIME_MASK = 8'hF8;

	// status nibbles of the running status
	localparam logic [3:0] MSG_NOTE_OFF   = 4'h8;
	localparam logic [3:0] MSG_NOTE_ON    = 4'h9;
	localparam logic [3:0] MSG_POLY_PRESS = 4'hA;
	localparam logic [3:0] MSG_CTRL_CHG   = 4'hB;
	localparam logic [3:0] MSG_PROG_CHG   = 4'hC;
	localparam logic [3:0] MSG_CHAN_PRESS = 4'hD;
	localparam logic [3:0] MSG_PITCH_BEND = 4'hE;
	localparam logic [3:0] MSG_SYSTEM     = 4'hF;

	// pitch table
	localparam int PITCH_ENTRIES = 24;
	localparam logic [7:0] PITCH_ENTRIES_W = 8'(PITCH_ENTRIES);
	localparam logic [11:0] PITCH_CODES [PITCH_ENTRIES] = '{
		12'd1000, 12'd1059, 12'd1122, 12'd1189, 12'd1260, 12'd1335,
		12'd1414, 12'd1498, 12'd1587, 12'd1682, 12'd1782, 12'd1888,
		12'd2000, 12'd2119, 12'd2245, 12'd2378, 12'd2520, 12'd2670,
		12'd2828, 12'd2997, 12'd3175, 12'd3364, 12'd3564, 12'd3775
	};

	// payload of one input word
	typedef struct packed {
		logic [7:0] midi_byte;
	} in_word_t;

	// payload of one result word
	typedef struct packed {
		logic [11:0] cv_code;
		logic        cv_written;
		logic        gate_on;
		logic [6:0]  top_note;
	} out_word_t;

	// completed note message from the parser
	typedef struct packed {
		logic       valid;
		logic       remove;
		logic [6:0] note;
	} note_event_t;

	// one stack slot
	typedef struct packed {
		logic       valid;
		logic [6:0] note;
	} stack_entry_t;

	// operation broadcast to every cell
	typedef enum logic [1:0] {
		OP_HOLD,
		OP_PUSH,
		OP_POP,
		OP_CLEAR
	} cell_op_t;

	typedef struct packed {
		cell_op_t   op;
		logic [6:0] key;
	} cell_ctrl_t;

	// remainder of a 7-bit value by restoring subtraction, seven narrow steps
	function automatic logic [6:0] mod_reduce(input logic [6:0] value,
			input logic [7:0] divisor);
		logic [14:0] rem;
		logic [14:0] trial;
		rem = {8'd0, value};
		for (int k = 6; k >= 0; k--) begin
			trial = {7'd0, divisor} << k;
			if (rem >= trial) begin
				rem = rem - trial;
			end
		end
		return rem[6:0];
	endfunction

	// pitch lookup, index already below the table length
	function automatic logic [11:0] pitch_code(input logic [6:0] idx);
		logic [11:0] code;
		code = '0;
		for (int i = 0; i < PITCH_ENTRIES; i++) begin
			if (idx == 7'(i)) begin
				code = PITCH_CODES[i];
			end
		end
		return code;
	endfunction

endpackage

@@ rtl/mnc_stream_if.sv @@
interface mnc_stream_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

@@ rtl/midi_note_to_cv_gate.sv @@
// sequence: a note on passes push, lookup and emit, with push first clearing a full stack;
//   a note off passes start, the search steps, pop while emptied slots are dropped, lookup and
//   emit; emit waits until the output register is free or cv takes its word
// input: other bytes leave the block idle and ready for the next byte; a note message holds
//   off input until its word is loaded; the search wave walks the cell chain one cell a cycle
// reset: arst_n clears the running status, empties the stack and drops any pending word
module midi_note_to_cv_gate #(
	parameter int STACK_DEPTH = mnc_pkg::STACK_DEPTH_DEF,
	parameter int TABLE_LEN   = mnc_pkg::TABLE_LEN_DEF
) (
	input logic         clk,
	input logic         arst_n,
	mnc_stream_if.sink   midi,
	mnc_stream_if.source cv
);
	import mnc_pkg::*;

	localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
	localparam int SRCH_W = $clog2(STACK_DEPTH);
	localparam logic [CNT_W-1:0]  FULL_COUNT = CNT_W'(STACK_DEPTH);
	localparam logic [SRCH_W-1:0] LAST_STEP  = SRCH_W'(STACK_DEPTH - 1);
	localparam logic [7:0] TABLE_LEN_W = 8'(TABLE_LEN);

	typedef enum logic [6:0] {
		ST_IDLE   = 7'b0000001,
		ST_PUSH   = 7'b0000010,
		ST_START  = 7'b0000100,
		ST_SEARCH = 7'b0001000,
		ST_POP    = 7'b0010000,
		ST_LOOKUP = 7'b0100000,
		ST_EMIT   = 7'b1000000
	} state_t;

	state_t            state_q;
	logic [CNT_W-1:0]  count_q;
	logic [SRCH_W-1:0] step_q;
	logic [6:0]        key_q;
	logic [6:0]        red_q;
	logic [6:0]        note_q;
	logic              gate_q;
	out_word_t         out_q;
	logic              out_valid_q;

	note_event_t       ev;
	cell_ctrl_t        ctrl;
	logic              accept;
	logic              load;
	logic [6:0]        pitch_idx;
	stack_entry_t      entry [STACK_DEPTH];
	logic [STACK_DEPTH:0] wave;

	assign midi.ready = (state_q == ST_IDLE);
	assign accept     = midi.valid && midi.ready;

	mnc_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.midi_byte (midi.data.midi_byte),
		.ev        (ev)
	);

	// chain of stack cells, slot 0 is the top of the stack
	assign wave[0] = (state_q == ST_START);

	for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
		stack_entry_t up_i;
		stack_entry_t down_i;
		if (i == 0) begin : g_head
			assign up_i = '{valid: 1'b1, note: key_q};
		end else begin : g_body
			assign up_i = entry[i-1];
		end
		if (i == STACK_DEPTH - 1) begin : g_tail
			assign down_i = '{valid: 1'b0, note: 7'd0};
		end else begin : g_inner
			assign down_i = entry[i+1];
		end
		mnc_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctrl     (ctrl),
			.up       (up_i),
			.down     (down_i),
			.wave_in  (wave[i]),
			.entry    (entry[i]),
			.wave_out (wave[i+1])
		);
	end

	// cell operation for this cycle
	always_comb begin
		ctrl.op  = OP_HOLD;
		ctrl.key = key_q;
		case (state_q)
			ST_PUSH: begin
				ctrl.op = (count_q == FULL_COUNT) ? OP_CLEAR : OP_PUSH;
			end
			ST_POP: begin
				if (count_q != '0 && !entry[0].valid) begin
					ctrl.op = OP_POP;
				end
			end
			default: begin
				ctrl.op = OP_HOLD;
			end
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			step_q  <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept && ev.valid) begin
						state_q <= ev.remove ? ST_START : ST_PUSH;
					end
				end
				ST_PUSH: begin
					// a full stack restarts empty, then takes the note
					if (count_q == FULL_COUNT) begin
						count_q <= '0;
					end else begin
						count_q <= count_q + 1'b1;
						state_q <= ST_LOOKUP;
					end
				end
				ST_START: begin
					step_q  <= '0;
					state_q <= ST_SEARCH;
				end
				ST_SEARCH: begin
					step_q <= step_q + 1'b1;
					if (step_q == LAST_STEP) begin
						state_q <= ST_POP;
					end
				end
				ST_POP: begin
					// drop emptied slots from the top
					if (count_q != '0 && !entry[0].valid) begin
						count_q <= count_q - 1'b1;
					end else begin
						state_q <= ST_LOOKUP;
					end
				end
				ST_LOOKUP: begin
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// note key and top note reduction
	always_ff @(posedge clk) begin
		if (accept && ev.valid) begin
			key_q <= ev.note;
		end
		if (state_q == ST_LOOKUP) begin
			red_q  <= mod_reduce(entry[0].note, TABLE_LEN_W);
			note_q <= entry[0].note;
			gate_q <= (count_q != '0);
		end
	end

	// output word register
	assign load      = (state_q == ST_EMIT) && (!out_valid_q || cv.ready);
	assign pitch_idx = mod_reduce(red_q, PITCH_ENTRIES_W);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (cv.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_q.cv_code    <= gate_q ? pitch_code(pitch_idx) : 12'd0;
			out_q.cv_written <= gate_q;
			out_q.gate_on    <= gate_q;
			out_q.top_note   <= gate_q ? note_q : 7'd0;
		end
	end

	assign cv.valid = out_valid_q;
	assign cv.data  = out_q;

	// checks
	a_one_wave: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(wave))
		else $error("more than one search wave in the cell chain");

	a_wave_end: assert property (@(posedge clk) disable iff (!arst_n)
		wave[STACK_DEPTH] |-> (state_q == ST_SEARCH) && (step_q == LAST_STEP))
		else $error("search wave left the chain outside the last search step");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FULL_COUNT)
		else $error("stack count beyond depth");

	a_top_live: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) && (count_q != '0) |-> entry[0].valid)
		else $error("top of a non-empty stack is an empty slot");

	a_gate_off: assert property (@(posedge clk) disable iff (!arst_n)
		cv.valid && !cv.data.gate_on |-> (cv.data.cv_code == 12'd0)
			&& !cv.data.cv_written && (cv.data.top_note == 7'd0))
		else $error("gate off word carries a note or code");
endmodule

@@ rtl/mnc_cell.sv @@
module mnc_cell (
	input  logic                 clk,
	input  logic                 arst_n,
	input  mnc_pkg::cell_ctrl_t   ctrl,
	input  mnc_pkg::stack_entry_t up,
	input  mnc_pkg::stack_entry_t down,
	input  logic                 wave_in,
	output mnc_pkg::stack_entry_t entry,
	output logic                 wave_out
);
	import mnc_pkg::*;

	logic       valid_q;
	logic [6:0] note_q;
	logic       wave_q;
	logic       hit;

	// search wave stops at the first live slot holding the key
	assign hit      = wave_q && valid_q && (note_q == ctrl.key);
	assign wave_out = wave_q && !hit;
	assign entry    = '{valid: valid_q, note: note_q};

	// slot occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			wave_q  <= 1'b0;
		end else begin
			wave_q <= wave_in;
			case (ctrl.op)
				OP_PUSH: begin
					valid_q <= up.valid;
				end
				OP_POP: begin
					valid_q <= down.valid;
				end
				OP_CLEAR: begin
					valid_q <= 1'b0;
				end
				default: begin
					if (hit) begin
						valid_q <= 1'b0;
					end
				end
			endcase
		end
	end

	// slot note, shifted with the occupancy
	always_ff @(posedge clk) begin
		case (ctrl.op)
			OP_PUSH: begin
				note_q <= up.note;
			end
			OP_POP: begin
				note_q <= down.note;
			end
			default: begin
				note_q <= note_q;
			end
		endcase
	end
endmodule

@@ rtl/mnc_parser.sv @@
module mnc_parser (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                accept,
	input  logic [7:0]          midi_byte,
	output mnc_pkg::note_event_t ev
);
	import mnc_pkg::*;

	logic [7:0] status_q;
	logic [1:0] count_q;
	logic [6:0] data0_q;
	logic [6:0] data1_q;

	logic [7:0] status_n;
	logic [1:0] count_n;
	logic [6:0] data0_n;
	logic [6:0] data1_n;
	logic       is_realtime;

	assign is_realtime = (midi_byte & REALTIME_MASK) == REALTIME_MASK;

	// running status, data collection and message completion
	always_comb begin
		status_n = status_q;
		count_n  = count_q;
		data0_n  = data0_q;
		data1_n  = data1_q;
		ev       = '0;
		if (accept && !is_realtime) begin
			if (midi_byte[7]) begin
				status_n = midi_byte;
				count_n  = 2'd0;
			end else if (status_q != 8'd0 && count_q < 2'd2) begin
				if (count_q == 2'd0) begin
					data0_n = midi_byte[6:0];
				end else begin
					data1_n = midi_byte[6:0];
				end
				count_n = count_q + 2'd1;
			end
			case (status_n[7:4])
				MSG_NOTE_OFF, MSG_NOTE_ON: begin
					if (count_n == 2'd2) begin
						count_n   = 2'd0;
						ev.valid  = 1'b1;
						ev.remove = (status_n[7:4] == MSG_NOTE_OFF) || (data1_n == 7'd0);
						ev.note   = data0_n;
					end
				end
				MSG_POLY_PRESS, MSG_CTRL_CHG, MSG_PITCH_BEND: begin
					if (count_n == 2'd2) begin
						count_n = 2'd0;
					end
				end
				MSG_PROG_CHG, MSG_CHAN_PRESS: begin
					if (count_n == 2'd1) begin
						count_n = 2'd0;
					end
				end
				MSG_SYSTEM: begin
					count_n = 2'd0;
				end
				default: begin
					count_n = count_n;
				end
			endcase
		end
	end

	// parser control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			status_q <= 8'd0;
			count_q  <= 2'd0;
		end else begin
			status_q <= status_n;
			count_q  <= count_n;
		end
	end

	// data bytes
	always_ff @(posedge clk) begin
		data0_q <= data0_n;
		data1_q <= data1_n;
	end
endmodule

@@ sim/testbench.sv @@
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import mnc_pkg::*;

	localparam int STACK_DEPTH = STACK_DEPTH_DEF;
	localparam int TABLE_LEN   = TABLE_LEN_DEF;
	localparam int ITEMS       = 1550;
	localparam int HOLD_CYCLES = 300;
	localparam int TAIL_CYCLES = 2 * STACK_DEPTH + 16;
	localparam logic [7:0] EMPTY_SLOT = 8'hFF;
	localparam out_word_t GATE_OFF = '0;

	// one row of the opening sequence; pinned rows carry a hand-worked word
	typedef struct packed {
		logic [7:0] b;
		logic       pinned;
		out_word_t  want;
	} stim_row_t;

	logic clk;
	logic arst_n;

	mnc_stream_if #(.T(in_word_t))  midi ();
	mnc_stream_if #(.T(out_word_t)) cv ();

	midi_note_to_cv_gate #(
		.STACK_DEPTH(STACK_DEPTH),
		.TABLE_LEN(TABLE_LEN)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.midi(midi),
		.cv(cv)
	);

	// parser and voice stack as the block should hold them
	logic [7:0] run_status = 8'h00;
	int         data_cnt = 0;
	logic [7:0] held [2] = '{8'h00, 8'h00};
	logic [7:0] voice_stack [STACK_DEPTH] = '{default: EMPTY_SLOT};
	int         voice_top = -1;

	out_word_t  cv_expect_q [$];
	out_word_t  next_cv;
	int         faults = 0;
	int         words_sent = 0;
	bit         gaps_on = 1'b1;
	bit         hold_off_req = 1'b0;
	logic [7:0] gen_status = 8'h00;
	logic [6:0] sounding_q [$];
	logic [3:0] other_kinds [5] = '{MSG_POLY_PRESS, MSG_CTRL_CHG, MSG_PROG_CHG,
		MSG_CHAN_PRESS, MSG_PITCH_BEND};

	// opening sequence: stray data, real-time, pushes at the note extremes,
	// a miss, removal below the top, velocity zero, stack emptied, system
	// common, program change and note off on an empty stack
	stim_row_t intro_rows [26] = '{
		'{8'h45, 1'b0, GATE_OFF},
		'{8'hF8, 1'b0, GATE_OFF},
		'{8'h90, 1'b0, GATE_OFF},
		'{8'h00, 1'b0, GATE_OFF},
		'{8'h7F, 1'b1, '{12'd1000, 1'b1, 1'b1, 7'd0}},
		'{8'h7F, 1'b0, GATE_OFF},
		'{8'h01, 1'b1, '{12'd1498, 1'b1, 1'b1, 7'd127}},
		'{8'h17, 1'b0, GATE_OFF},
		'{8'h40, 1'b1, '{12'd3775, 1'b1, 1'b1, 7'd23}},
		'{8'h8F, 1'b0, GATE_OFF},
		'{8'h05, 1'b0, GATE_OFF},
		'{8'h00, 1'b1, '{12'd3775, 1'b1, 1'b1, 7'd23}},
		'{8'h00, 1'b0, GATE_OFF},
		'{8'h40, 1'b1, '{12'd3775, 1'b1, 1'b1, 7'd23}},
		'{8'h9A, 1'b0, GATE_OFF},
		'{8'h17, 1'b0, GATE_OFF},
		'{8'h00, 1'b1, '{12'd1498, 1'b1, 1'b1, 7'd127}},
		'{8'h7F, 1'b0, GATE_OFF},
		'{8'h00, 1'b1, GATE_OFF},
		'{8'hF2, 1'b0, GATE_OFF},
		'{8'h10, 1'b0, GATE_OFF},
		'{8'hC5, 1'b0, GATE_OFF},
		'{8'h0A, 1'b0, GATE_OFF},
		'{8'h80, 1'b0, GATE_OFF},
		'{8'h10, 1'b0, GATE_OFF},
		'{8'h10, 1'b1, GATE_OFF}
	};

	// clock
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// advance the parser by one byte, giving the cv word when a note message completes
	task automatic predict_cv(input logic [7:0] b, output bit fires, output out_word_t w);
		logic [3:0] kind;
		logic [7:0] n;
		int p;
		fires = 1'b0;
		w = GATE_OFF;
		if ((b & REALTIME_MASK) == REALTIME_MASK) return;
		if (b[7]) begin
			run_status = b;
			data_cnt = 0;
		end else if (run_status != 8'h00 && data_cnt < 2) begin
			held[data_cnt] = b;
			data_cnt++;
		end
		kind = run_status[7:4];
		case (kind)
			MSG_NOTE_OFF, MSG_NOTE_ON: begin
				if (data_cnt == 2) begin
					data_cnt = 0;
					fires = 1'b1;
					if (kind == MSG_NOTE_OFF || held[1] == 8'h00) begin
						// clear the topmost match; popping the top drops empties under it
						p = voice_top;
						while (p >= 0 && voice_stack[p] != held[0]) p--;
						if (p >= 0) begin
							voice_stack[p] = EMPTY_SLOT;
							if (p == voice_top) begin
								while (voice_top >= 0 && voice_stack[voice_top] == EMPTY_SLOT)
									voice_top--;
							end
						end
					end else begin
						// a full stack starts again from the bottom
						if (voice_top >= STACK_DEPTH - 1) voice_top = -1;
						voice_top++;
						voice_stack[voice_top] = held[0];
					end
					if (voice_top >= 0) begin
						n = voice_stack[voice_top];
						w.cv_code = PITCH_CODES[(int'(n) % TABLE_LEN) % PITCH_ENTRIES];
						w.cv_written = 1'b1;
						w.gate_on = 1'b1;
						w.top_note = n[6:0];
					end
				end
			end
			MSG_POLY_PRESS, MSG_CTRL_CHG, MSG_PITCH_BEND: begin
				if (data_cnt == 2) data_cnt = 0;
			end
			MSG_PROG_CHG, MSG_CHAN_PRESS: begin
				if (data_cnt == 1) data_cnt = 0;
			end
			MSG_SYSTEM: begin
				data_cnt = 0;
			end
			default: begin
			end
		endcase
	endtask

	// offer one byte, wait for the handshake, then log what it should cause
	task automatic send_byte(input logic [7:0] b, input bit pinned, input out_word_t pinned_word);
		bit fires;
		out_word_t w;
		while (gaps_on && $urandom_range(99) < 37) begin
			midi.valid <= 1'b0;
			@(posedge clk);
		end
		midi.valid <= 1'b1;
		midi.data.midi_byte <= b;
		@(posedge clk);
		while (!midi.ready) @(posedge clk);
		predict_cv(b, fires, w);
		if (fires) cv_expect_q.push_back(pinned ? pinned_word : w);
		if ((b & REALTIME_MASK) != REALTIME_MASK) words_sent++;
	endtask

	// one channel message, running status used at random, real-time bytes slipped in
	task automatic send_message(input logic [7:0] st, input int n_data,
			input logic [7:0] d0, input logic [7:0] d1);
		if (st != gen_status || $urandom_range(1) == 0) begin
			send_byte(st, 1'b0, GATE_OFF);
			gen_status = st;
		end
		if (n_data > 0) begin
			if ($urandom_range(99) < 6) send_byte(8'($urandom_range(8'hF8, 8'hFF)), 1'b0, GATE_OFF);
			send_byte(d0, 1'b0, GATE_OFF);
		end
		if (n_data > 1) begin
			if ($urandom_range(99) < 6) send_byte(8'($urandom_range(8'hF8, 8'hFF)), 1'b0, GATE_OFF);
			send_byte(d1, 1'b0, GATE_OFF);
		end
	endtask

	// stimulus
	initial begin
		logic [7:0] st;
		logic [6:0] note;
		logic [3:0] kind;
		int r;
		int idx;
		bit stalled_once;
		bit drained_once;
		stalled_once = 1'b0;
		drained_once = 1'b0;
		arst_n = 1'b0;
		midi.valid <= 1'b0;
		midi.data <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (intro_rows[i]) send_byte(intro_rows[i].b, intro_rows[i].pinned, intro_rows[i].want);

		while (words_sent < ITEMS) begin
			// long receiver hold-off, a drain pause and a stretch with no gaps
			if (!stalled_once && words_sent >= 400) begin
				stalled_once = 1'b1;
				hold_off_req = 1'b1;
			end
			if (!drained_once && words_sent >= 1100) begin
				drained_once = 1'b1;
				midi.valid <= 1'b0;
				while (cv_expect_q.size() != 0) @(posedge clk);
			end
			gaps_on = !(words_sent >= 700 && words_sent < 950);

			r = $urandom_range(99);
			if (r < 50) begin
				// note on, sometimes repeating a note already held
				if (sounding_q.size() != 0 && $urandom_range(99) < 20)
					note = sounding_q[$urandom_range(sounding_q.size() - 1)];
				else
					note = 7'($urandom_range(127));
				sounding_q.push_back(note);
				if (sounding_q.size() > STACK_DEPTH) void'(sounding_q.pop_front());
				send_message({MSG_NOTE_ON, 4'($urandom_range(15))}, 2, {1'b0, note},
					8'($urandom_range(1, 127)));
			end else if (r < 78) begin
				// note off, mostly of a held note, either form
				if (sounding_q.size() != 0 && $urandom_range(99) < 85) begin
					idx = $urandom_range(sounding_q.size() - 1);
					note = sounding_q[idx];
					sounding_q.delete(idx);
				end else begin
					note = 7'($urandom_range(127));
				end
				if ($urandom_range(1) == 0)
					send_message({MSG_NOTE_OFF, 4'($urandom_range(15))}, 2, {1'b0, note},
						8'($urandom_range(127)));
				else
					send_message({MSG_NOTE_ON, 4'($urandom_range(15))}, 2, {1'b0, note}, 8'h00);
			end else if (r < 88) begin
				// other channel messages, consumed without a word
				kind = other_kinds[$urandom_range(4)];
				send_message({kind, 4'($urandom_range(15))},
					(kind == MSG_PROG_CHG || kind == MSG_CHAN_PRESS) ? 1 : 2,
					8'($urandom_range(127)), 8'($urandom_range(127)));
			end else begin
				// noise and broken sequences
				case ($urandom_range(3))
					0: send_byte(8'($urandom_range(8'hF8, 8'hFF)), 1'b0, GATE_OFF);
					1: begin
						st = 8'($urandom_range(8'hF0, 8'hF7));
						send_byte(st, 1'b0, GATE_OFF);
						gen_status = st;
						repeat ($urandom_range(2)) send_byte(8'($urandom_range(127)), 1'b0, GATE_OFF);
					end
					2: send_byte(8'($urandom_range(127)), 1'b0, GATE_OFF);
					default: begin
						st = {($urandom_range(1) == 0) ? MSG_NOTE_OFF : MSG_NOTE_ON,
							4'($urandom_range(15))};
						send_byte(st, 1'b0, GATE_OFF);
						gen_status = st;
						send_byte(8'($urandom_range(127)), 1'b0, GATE_OFF);
					end
				endcase
			end
		end
		midi.valid <= 1'b0;

		while (cv_expect_q.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (faults == 0 && cv_expect_q.size() == 0)
			$display("testbench: clean");
		else
			$display("testbench: errors");
		$finish;
	end

	// receiver: random ready, with one long hold-off on request
	initial begin
		cv.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				repeat (HOLD_CYCLES) begin
					cv.ready <= 1'b0;
					@(posedge clk);
				end
			end
			cv.ready <= !gaps_on || $urandom_range(99) >= 37;
		end
	end

	// compare each accepted cv word with the oldest expectation
	always @(posedge clk) begin
		if (arst_n && cv.valid && cv.ready) begin
			if (cv_expect_q.size() == 0) begin
				$error("cv word %h with nothing expected", cv.data);
				faults++;
			end else begin
				next_cv = cv_expect_q.pop_front();
				if (cv.data.cv_code !== next_cv.cv_code) begin
					$error("cv_code: expected %0d, got %0d", next_cv.cv_code, cv.data.cv_code);
					faults++;
				end
				if (cv.data.cv_written !== next_cv.cv_written) begin
					$error("cv_written: expected %0d, got %0d", next_cv.cv_written,
						cv.data.cv_written);
					faults++;
				end
				if (cv.data.gate_on !== next_cv.gate_on) begin
					$error("gate_on: expected %0d, got %0d", next_cv.gate_on, cv.data.gate_on);
					faults++;
				end
				if (cv.data.top_note !== next_cv.top_note) begin
					$error("top_note: expected %0d, got %0d", next_cv.top_note, cv.data.top_note);
					faults++;
				end
			end
		end
	end

	// watchdog
	initial begin
		#5_000_000;
		$display("testbench: errors");
		$finish;
	end

endmodule
